// ----- src/scmi_pkg.sv -----
// Shared types, widths and constants of the smoothed camera motion integrator.
package scmi_pkg;

  localparam int FRAC_BITS = 8;
  localparam int UNIT      = 1 << FRAC_BITS;

  localparam int STATE_W  = 24;
  localparam int AXIS_W   = 10;
  localparam int GAIN_W   = 16;
  localparam int ACCEL_W  = 17;
  localparam int STEP_W   = 16;
  localparam int NUM_AXES = 5;
  localparam int NUM_POS  = 3;
  localparam int NUM_ANG  = 2;

  localparam int POS_W = 15;
  localparam int ANG_W = 17;
  localparam int FOV_W = 15;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 96;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // gain is Q8.8, accel_factor Q1.16
  localparam int GAIN_SHIFT     = 8;
  localparam int ACCEL_SHIFT    = 16;
  localparam int FOV_STEP_SHIFT = 2;

  localparam logic [ACCEL_W-1:0] ACCEL_ONE = ACCEL_W'(65536);

  localparam logic [ACCEL_W-1:0] ACCEL_RST     = ACCEL_W'(6554);
  localparam logic [GAIN_W-1:0]  FAST_POS_RST  = GAIN_W'(512);
  localparam logic [GAIN_W-1:0]  NORM_POS_RST  = GAIN_W'(256);
  localparam logic [GAIN_W-1:0]  FAST_ROT_RST  = GAIN_W'(512);
  localparam logic [GAIN_W-1:0]  NORM_ROT_RST  = GAIN_W'(256);

  localparam int POS_LIMIT   = 50 * UNIT;
  localparam int ANG_LIMIT   = 180 * UNIT;
  localparam int FOV_DEFAULT = 75 * UNIT;
  localparam int FOV_MIN     = 5 * UNIT;
  localparam int FOV_MAX     = 90 * UNIT;
  localparam int FOV_FLOOR   = -256 * UNIT;
  localparam int FOV_RESTORE = -90 * UNIT;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL         = 3'd0,
    REG_FAST_POS_GAIN = 3'd1,
    REG_NORM_POS_GAIN = 3'd2,
    REG_FAST_ROT_GAIN = 3'd3,
    REG_NORM_ROT_GAIN = 3'd4
  } cfg_reg_t;

  typedef logic signed [STATE_W-1:0] state_t;

  typedef struct packed {
    logic upd;
    logic tick;
  } ctrl_t;

  typedef struct packed {
    logic [ACCEL_W-1:0] accel;
    logic [GAIN_W-1:0]  fast_pos_gain;
    logic [GAIN_W-1:0]  norm_pos_gain;
    logic [GAIN_W-1:0]  fast_rot_gain;
    logic [GAIN_W-1:0]  norm_rot_gain;
  } cfg_t;

  // x sits in the lowest bits
  typedef struct packed {
    logic        [FOV_W-1:0] fov;
    logic signed [ANG_W-1:0] tilt;
    logic signed [ANG_W-1:0] pan;
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } pose_t;

endpackage

// ----- src/scmi_cfg_regs.sv -----
// Configuration register file: accel factor and the four gains.
module scmi_cfg_regs import scmi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  logic [ACCEL_W-1:0] accel_r;
  logic [GAIN_W-1:0]  fast_pos_r;
  logic [GAIN_W-1:0]  norm_pos_r;
  logic [GAIN_W-1:0]  fast_rot_r;
  logic [GAIN_W-1:0]  norm_rot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r    <= ACCEL_RST;
      fast_pos_r <= FAST_POS_RST;
      norm_pos_r <= NORM_POS_RST;
      fast_rot_r <= FAST_ROT_RST;
      norm_rot_r <= NORM_ROT_RST;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_ACCEL:         accel_r    <= wr_data[ACCEL_W-1:0];
        REG_FAST_POS_GAIN: fast_pos_r <= wr_data[GAIN_W-1:0];
        REG_NORM_POS_GAIN: norm_pos_r <= wr_data[GAIN_W-1:0];
        REG_FAST_ROT_GAIN: fast_rot_r <= wr_data[GAIN_W-1:0];
        REG_NORM_ROT_GAIN: norm_rot_r <= wr_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // factor above one acts as one
  assign cfg.accel         = (accel_r > ACCEL_ONE) ? ACCEL_ONE : accel_r;
  assign cfg.fast_pos_gain = fast_pos_r;
  assign cfg.norm_pos_gain = norm_pos_r;
  assign cfg.fast_rot_gain = fast_rot_r;
  assign cfg.norm_rot_gain = norm_rot_r;

endmodule

// ----- src/scmi_axis.sv -----
// One motion axis: velocity target from stick times gain, and smoothed velocity.
module scmi_axis import scmi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_t                    ctrl,
  input  logic signed [AXIS_W-1:0] axis_val,
  input  logic [GAIN_W-1:0]        gain,
  input  logic [ACCEL_W-1:0]       accel,
  output state_t                   vel_nxt
);

  localparam int PROD_W = AXIS_W + GAIN_W + 1;
  localparam int DIFF_W = STATE_W + 1;
  localparam int MIX_W  = DIFF_W + ACCEL_W + 1;

  state_t                    tgt_r;
  state_t                    vel_r;
  state_t                    tgt_nxt;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [MIX_W-1:0]   mix;
  logic signed [MIX_W-1:0]   mix_rnd;

  // |target| stays below 2^18, so the cut to 24 bits never loses anything
  assign prod     = PROD_W'(axis_val) * $signed({1'b0, gain});
  assign prod_rnd = prod + PROD_W'(1 << (GAIN_SHIFT - 1));
  assign tgt_nxt  = STATE_W'(prod_rnd >>> GAIN_SHIFT);

  // v*(1-a) + t*a == v + (t-v)*a
  assign diff    = DIFF_W'(tgt_r) - DIFF_W'(vel_r);
  assign mix     = MIX_W'(diff) * $signed({1'b0, accel});
  assign mix_rnd = mix + MIX_W'(1 << (ACCEL_SHIFT - 1));
  assign vel_nxt = vel_r + STATE_W'(mix_rnd >>> ACCEL_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
      vel_r <= '0;
    end else begin
      if (ctrl.upd) begin
        tgt_r <= tgt_nxt;
      end
      if (ctrl.tick) begin
        vel_r <= vel_nxt;
      end
    end
  end

endmodule

// ----- src/scmi_pose.sv -----
// Pose state: position clamp, angle wrap and field-of-view step and limits.
module scmi_pose import scmi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_t                    ctrl,
  input  logic                     pos_reset,
  input  logic                     rot_reset,
  input  logic signed [STEP_W-1:0] fov_step,
  input  state_t                   vel [NUM_AXES],
  output pose_t                    pose_nxt
);

  localparam int SUM_W     = STATE_W + 1;
  localparam int FOV_SUM_W = STATE_W + 2;

  localparam logic signed [SUM_W-1:0]     POS_HI = SUM_W'(POS_LIMIT);
  localparam logic signed [SUM_W-1:0]     POS_LO = SUM_W'(-POS_LIMIT);
  localparam logic signed [SUM_W-1:0]     ANG_HI = SUM_W'(ANG_LIMIT);
  localparam logic signed [SUM_W-1:0]     ANG_LO = SUM_W'(-ANG_LIMIT);
  localparam state_t                      FOV_DEF  = STATE_W'(FOV_DEFAULT);
  localparam state_t                      FOV_LO_S = STATE_W'(FOV_MIN);
  localparam state_t                      FOV_HI_S = STATE_W'(FOV_MAX);
  localparam logic signed [FOV_SUM_W-1:0] FOV_FLOOR_S   = FOV_SUM_W'(FOV_FLOOR);
  localparam logic signed [STEP_W-1:0]    FOV_RESTORE_S = STEP_W'(FOV_RESTORE);

  state_t                       pos_r    [NUM_POS];
  state_t                       pos_tick [NUM_POS];
  state_t                       ang_r    [NUM_ANG];
  state_t                       ang_tick [NUM_ANG];
  state_t                       fov_r;
  state_t                       fov_tick;
  state_t                       fov_base;
  state_t                       fov_upd;
  logic signed [SUM_W-1:0]      pos_sum  [NUM_POS];
  logic signed [SUM_W-1:0]      ang_sum  [NUM_ANG];
  logic signed [FOV_SUM_W-1:0]  fov_sum;

  always_comb begin
    for (int i = 0; i < NUM_POS; i++) begin
      pos_sum[i] = SUM_W'(pos_r[i]) + SUM_W'(vel[i]);
      if (pos_sum[i] < POS_LO) begin
        pos_tick[i] = STATE_W'(POS_LO);
      end else if (pos_sum[i] > POS_HI) begin
        pos_tick[i] = STATE_W'(POS_HI);
      end else begin
        pos_tick[i] = STATE_W'(pos_sum[i]);
      end
    end
    // passing one bound lands on the other
    for (int i = 0; i < NUM_ANG; i++) begin
      ang_sum[i] = SUM_W'(ang_r[i]) + SUM_W'(vel[NUM_POS + i]);
      if (ang_sum[i] < ANG_LO) begin
        ang_tick[i] = STATE_W'(ANG_HI);
      end else if (ang_sum[i] > ANG_HI) begin
        ang_tick[i] = STATE_W'(ANG_LO);
      end else begin
        ang_tick[i] = STATE_W'(ang_sum[i]);
      end
    end
    fov_tick = (fov_r < FOV_LO_S) ? FOV_LO_S : fov_r;

    fov_base = rot_reset ? FOV_DEF : fov_r;
    fov_sum  = FOV_SUM_W'(fov_base) + (FOV_SUM_W'(fov_step) <<< FOV_STEP_SHIFT);
    if (fov_step > FOV_RESTORE_S) begin
      fov_upd = (fov_sum < FOV_FLOOR_S) ? STATE_W'(FOV_FLOOR_S) : STATE_W'(fov_sum);
    end else begin
      fov_upd = FOV_DEF;
    end
    if (fov_upd > FOV_HI_S) begin
      fov_upd = FOV_HI_S;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POS; i++) begin
        pos_r[i] <= '0;
      end
      for (int i = 0; i < NUM_ANG; i++) begin
        ang_r[i] <= '0;
      end
      fov_r <= FOV_DEF;
    end else if (ctrl.tick) begin
      for (int i = 0; i < NUM_POS; i++) begin
        pos_r[i] <= pos_tick[i];
      end
      for (int i = 0; i < NUM_ANG; i++) begin
        ang_r[i] <= ang_tick[i];
      end
      fov_r <= fov_tick;
    end else if (ctrl.upd) begin
      if (pos_reset) begin
        for (int i = 0; i < NUM_POS; i++) begin
          pos_r[i] <= '0;
        end
      end
      if (rot_reset) begin
        for (int i = 0; i < NUM_ANG; i++) begin
          ang_r[i] <= '0;
        end
      end
      fov_r <= fov_upd;
    end
  end

  assign pose_nxt.x    = pos_tick[0][POS_W-1:0];
  assign pose_nxt.y    = pos_tick[1][POS_W-1:0];
  assign pose_nxt.z    = pos_tick[2][POS_W-1:0];
  assign pose_nxt.pan  = ang_tick[0][ANG_W-1:0];
  assign pose_nxt.tilt = ang_tick[1][ANG_W-1:0];
  assign pose_nxt.fov  = fov_tick[FOV_W-1:0];

endmodule

// ----- src/smoothed_camera_motion_integrator.sv -----
// Top level of the smoothed camera motion integrator.
//
// Input stream (in_*): one word per item. in_tuser is the command: 0 is a
// joystick update, 1 is a tick. An update loads the five velocity targets,
// applies the reset flags and steps the field of view; it gives no output.
// A tick smooths the velocities, integrates the pose and sends one pose
// word on the output stream (out_*).
// Config channel (cfg_*): always ready; cfg_index 0..4 selects accel factor,
// fast/normal position gain, fast/normal rotation gain. Other indexes are
// dropped. Write only while the block is idle.
// Timing: a word is registered on accept in the input register and processed
// from there through one pass of the per-axis multipliers (10x17 for targets,
// 25x18 for velocities); a tick's pose is registered in the output register.
// One word per cycle sustained while the output is not stalled.
// Stall: the output register holds the pose until out_tready; a tick that
// meets a full, stalled output waits in the input register and in_tready
// drops. Updates waiting behind it wait too.
// Reset (rst_n low, synchronous): registers to defaults, pose and velocities
// to zero, field of view to 75 degrees, both streams empty.
module smoothed_camera_motion_integrator import scmi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // axis_x, axis_y, axis_z, axis_pan, axis_tilt, position_reset,
  // rotation_reset, fast_position, fast_rotation, fov_step, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pose_x, pose_y, pose_z, pose_pan, pose_tilt, pose_fov, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FLAG_LSB = NUM_AXES * AXIS_W;
  localparam int STEP_LSB = FLAG_LSB + 4;

  logic                  in_vld_r;
  logic                  in_cmd_r;
  logic [IN_DATA_W-1:0]  in_data_r;
  logic                  out_vld_r;
  pose_t                 out_pose_r;
  logic                  adv;
  ctrl_t                 ctrl;
  cfg_t                  cfg;
  pose_t                 pose_nxt;
  state_t                vel [NUM_AXES];
  logic [GAIN_W-1:0]     pos_gain;
  logic [GAIN_W-1:0]     rot_gain;
  logic                  pos_reset;
  logic                  rot_reset;
  logic                  fast_pos;
  logic                  fast_rot;
  logic signed [STEP_W-1:0] fov_step;

  assign cfg_ready = 1'b1;

  scmi_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign adv = in_vld_r && ((cmd_t'(in_cmd_r) == CMD_UPDATE) || !out_vld_r || out_tready);
  assign ctrl.upd  = adv && (cmd_t'(in_cmd_r) == CMD_UPDATE);
  assign ctrl.tick = adv && (cmd_t'(in_cmd_r) == CMD_TICK);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_cmd_r  <= in_tuser;
      in_data_r <= in_tdata;
    end
  end

  assign pos_reset = in_data_r[FLAG_LSB];
  assign rot_reset = in_data_r[FLAG_LSB + 1];
  assign fast_pos  = in_data_r[FLAG_LSB + 2];
  assign fast_rot  = in_data_r[FLAG_LSB + 3];
  assign fov_step  = in_data_r[STEP_LSB +: STEP_W];

  assign pos_gain = fast_pos ? cfg.fast_pos_gain : cfg.norm_pos_gain;
  assign rot_gain = fast_rot ? cfg.fast_rot_gain : cfg.norm_rot_gain;

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    scmi_axis u_axis (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .axis_val (in_data_r[k*AXIS_W +: AXIS_W]),
      .gain     ((k < NUM_POS) ? pos_gain : rot_gain),
      .accel    (cfg.accel),
      .vel_nxt  (vel[k])
    );
  end

  scmi_pose u_pose (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .pos_reset (pos_reset),
    .rot_reset (rot_reset),
    .fov_step  (fov_step),
    .vel       (vel),
    .pose_nxt  (pose_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctrl.tick) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tick) begin
      out_pose_r <= pose_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_pose_r);

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !ctrl.tick)
    else $error("tick processed into a stalled output word");

  a_tick_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.tick |=> out_tvalid)
    else $error("tick did not produce an output word");

  a_fov_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_pose_r.fov >= FOV_W'(FOV_MIN)) && (out_pose_r.fov <= FOV_W'(FOV_MAX)))
    else $error("field of view out of range");

  a_stall_blocks_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && in_cmd_r && out_vld_r && !out_tready) |-> !in_tready)
    else $error("input accepted while a tick is blocked");
`endif

endmodule

// ----- dv/smoothed_camera_motion_integrator_tb.sv -----
// Testbench for the smoothed camera motion integrator: directed table, then random words vs. a pose predictor.
module smoothed_camera_motion_integrator_tb;
  import scmi_pkg::*;

  localparam int NUM_REGS     = 5;
  localparam int NUM_PHASES   = 6;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;

  localparam longint ACCEL_UNIT = 64'sd1 <<< ACCEL_SHIFT;
  localparam longint GAIN_HALF  = 64'sd1 <<< (GAIN_SHIFT - 1);
  localparam longint S24_HI     = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
  localparam longint S24_LO     = -(64'sd1 <<< (STATE_W - 1));
  localparam longint POS_LIM    = POS_LIMIT;
  localparam longint ANG_LIM    = ANG_LIMIT;
  localparam longint FOV_DEF    = FOV_DEFAULT;
  localparam longint FOV_LO     = FOV_MIN;
  localparam longint FOV_HI     = FOV_MAX;
  localparam longint FOV_BOTTOM = FOV_FLOOR;
  localparam longint FOV_RESET  = FOV_RESTORE;

  // laid out exactly as in_tdata, axis_x lowest
  typedef struct packed {
    logic signed [STEP_W-1:0]           step;
    logic                               fast_rot;
    logic                               fast_pos;
    logic                               rot_rst;
    logic                               pos_rst;
    logic [NUM_AXES-1:0][AXIS_W-1:0]    axis;
  } stick_word_t;

  typedef struct packed {
    cmd_t        cmd;
    stick_word_t w;
    logic        typed;
    pose_t       pose;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  smoothed_camera_motion_integrator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // pose predictor state and register copies
  longint cam_pos [NUM_POS];
  longint cam_ang [NUM_ANG];
  longint cam_fov;
  longint vel_now [NUM_AXES];
  longint vel_goal [NUM_AXES];
  longint accel_now, fast_pos_gain, norm_pos_gain, fast_rot_gain, norm_rot_gain;

  pose_t     pose_due [$];
  plan_row_t plan [$];
  int        mismatches  = 0;
  int        quiet_cycles = 0;
  int        send_gap    = 0;
  int        recv_gap    = 0;
  pose_t     seen_pose, due_pose;

  cfg_reg_t reg_order [NUM_REGS] = '{REG_ACCEL, REG_FAST_POS_GAIN, REG_NORM_POS_GAIN,
                                     REG_FAST_ROT_GAIN, REG_NORM_ROT_GAIN};

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pose_t pose_of(longint x, longint y, longint z, longint pan,
                                    longint tilt, longint fov);
    pose_t p;
    p.x    = x[POS_W-1:0];
    p.y    = y[POS_W-1:0];
    p.z    = z[POS_W-1:0];
    p.pan  = pan[ANG_W-1:0];
    p.tilt = tilt[ANG_W-1:0];
    p.fov  = fov[FOV_W-1:0];
    return p;
  endfunction

  function automatic void apply_stick_update(stick_word_t w);
    longint pg, rg, ax, st;
    pg = w.fast_pos ? fast_pos_gain : norm_pos_gain;
    rg = w.fast_rot ? fast_rot_gain : norm_rot_gain;
    for (int i = 0; i < NUM_AXES; i++) begin
      ax = longint'($signed(w.axis[i]));
      vel_goal[i] = clamp((ax * ((i < NUM_POS) ? pg : rg) + GAIN_HALF) >>> GAIN_SHIFT,
                          S24_LO, S24_HI);
    end
    if (w.pos_rst) begin
      for (int i = 0; i < NUM_POS; i++) cam_pos[i] = 0;
    end
    if (w.rot_rst) begin
      for (int i = 0; i < NUM_ANG; i++) cam_ang[i] = 0;
      cam_fov = FOV_DEF;
    end
    st = longint'(w.step);
    if (st > FOV_RESET) begin
      cam_fov = cam_fov + (st <<< FOV_STEP_SHIFT);
      if (cam_fov < FOV_BOTTOM) cam_fov = FOV_BOTTOM;
    end else begin
      cam_fov = FOV_DEF;
    end
    if (cam_fov > FOV_HI) cam_fov = FOV_HI;
  endfunction

  function automatic pose_t advance_pose();
    longint a, p;
    a = (accel_now > ACCEL_UNIT) ? ACCEL_UNIT : accel_now;
    for (int i = 0; i < NUM_AXES; i++)
      vel_now[i] = (vel_now[i] * (ACCEL_UNIT - a) + vel_goal[i] * a + (ACCEL_UNIT >>> 1))
                   >>> ACCEL_SHIFT;
    for (int i = 0; i < NUM_POS; i++)
      cam_pos[i] = clamp(cam_pos[i] + vel_now[i], -POS_LIM, POS_LIM);
    for (int i = 0; i < NUM_ANG; i++) begin
      p = cam_ang[i] + vel_now[NUM_POS + i];
      if (p < -ANG_LIM) p = ANG_LIM;
      else if (p > ANG_LIM) p = -ANG_LIM;
      cam_ang[i] = p;
    end
    if (cam_fov < FOV_LO) cam_fov = FOV_LO;
    return pose_of(cam_pos[0], cam_pos[1], cam_pos[2], cam_ang[0], cam_ang[1], cam_fov);
  endfunction

  function automatic plan_row_t upd_row(int x, int y, int z, int pan, int tilt, bit pr,
                                        bit rr, bit fp, bit fr, int step);
    plan_row_t r;
    r = '0;
    r.cmd        = CMD_UPDATE;
    r.w.axis[0]  = AXIS_W'(x);
    r.w.axis[1]  = AXIS_W'(y);
    r.w.axis[2]  = AXIS_W'(z);
    r.w.axis[3]  = AXIS_W'(pan);
    r.w.axis[4]  = AXIS_W'(tilt);
    r.w.pos_rst  = pr;
    r.w.rot_rst  = rr;
    r.w.fast_pos = fp;
    r.w.fast_rot = fr;
    r.w.step     = STEP_W'(step);
    return r;
  endfunction

  function automatic plan_row_t tick_row(bit typed, pose_t pose);
    plan_row_t r;
    r = '0;
    r.cmd   = CMD_TICK;
    r.typed = typed;
    r.pose  = pose;
    return r;
  endfunction

  function automatic stick_word_t random_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(stick_word_t)-1:0];
  endfunction

  function automatic stick_word_t random_update();
    stick_word_t w;
    w = random_word();
    for (int i = 0; i < NUM_AXES; i++) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0:       w.axis[i] = AXIS_W'(-512);
          1:       w.axis[i] = AXIS_W'(-256);
          2:       w.axis[i] = '0;
          3:       w.axis[i] = AXIS_W'(256);
          default: w.axis[i] = AXIS_W'(511);
        endcase
      end
    end
    w.pos_rst = ($urandom_range(15) == 0);
    w.rot_rst = ($urandom_range(15) == 0);
    case ($urandom_range(9))
      0:       ;
      1:       w.step = STEP_W'(FOV_RESTORE + int'($urandom_range(2)) - 1);
      2:       w.step = $urandom_range(1) ? STEP_W'(32767) : STEP_W'(-32768);
      default: w.step = STEP_W'(int'($urandom_range(512)) - 256);
    endcase
    return w;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(cmd_t c, stick_word_t w, bit typed, pose_t typed_pose);
    pose_t p;
    while ($urandom_range(99) < send_gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= IN_DATA_W'(w);
    do @(posedge clk); while (!in_tready);
    if (c == CMD_TICK) begin
      p = advance_pose();
      pose_due.push_back(typed ? typed_pose : p);
    end else begin
      apply_stick_update(w);
    end
  endtask

  task automatic load_regs(longint acc, longint fpg, longint npg, longint frg, longint nrg);
    longint v [NUM_REGS];
    v = '{acc, fpg, npg, frg, nrg};
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= CFG_DATA_W'(v[i]);
      do @(posedge clk); while (!cfg_ready);
      case (reg_order[i])
        REG_ACCEL:         accel_now     = v[i];
        REG_FAST_POS_GAIN: fast_pos_gain = v[i];
        REG_NORM_POS_GAIN: norm_pos_gain = v[i];
        REG_FAST_ROT_GAIN: fast_rot_gain = v[i];
        REG_NORM_ROT_GAIN: norm_rot_gain = v[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // updates give no word, so let the pipeline empty after the last pose
  task automatic wait_idle();
    while (pose_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_gap);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_pose = pose_t'(out_tdata[$bits(pose_t)-1:0]);
      if (pose_due.size() == 0) begin
        $error("pose word with nothing expected");
        mismatches++;
      end else begin
        due_pose = pose_due.pop_front();
        check_field("pose_x", int'(due_pose.x), int'(seen_pose.x));
        check_field("pose_y", int'(due_pose.y), int'(seen_pose.y));
        check_field("pose_z", int'(due_pose.z), int'(seen_pose.z));
        check_field("pose_pan", int'(due_pose.pan), int'(seen_pose.pan));
        check_field("pose_tilt", int'(due_pose.tilt), int'(seen_pose.tilt));
        check_field("pose_fov", int'(due_pose.fov), int'(seen_pose.fov));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    int burst;
    accel_now     = longint'(ACCEL_RST);
    fast_pos_gain = longint'(FAST_POS_RST);
    norm_pos_gain = longint'(NORM_POS_RST);
    fast_rot_gain = longint'(FAST_ROT_RST);
    norm_rot_gain = longint'(NORM_ROT_RST);
    for (int i = 0; i < NUM_AXES; i++) begin
      vel_now[i]  = 0;
      vel_goal[i] = 0;
    end
    for (int i = 0; i < NUM_POS; i++) cam_pos[i] = 0;
    for (int i = 0; i < NUM_ANG; i++) cam_ang[i] = 0;
    cam_fov = FOV_DEF;

    // directed table, reset register values
    plan.push_back(tick_row(1'b1, pose_of(0, 0, 0, 0, 0, FOV_DEF)));
    plan.push_back(upd_row(0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0, 32767));
    plan.push_back(tick_row(1'b1, pose_of(0, 0, 0, 0, 0, FOV_HI)));
    plan.push_back(upd_row(0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0, -32768));
    plan.push_back(tick_row(1'b1, pose_of(0, 0, 0, 0, 0, FOV_DEF)));
    plan.push_back(upd_row(0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0, UNIT));
    plan.push_back(tick_row(1'b0, '0));
    plan.push_back(upd_row(0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0, FOV_RESTORE));
    plan.push_back(tick_row(1'b1, pose_of(0, 0, 0, 0, 0, FOV_DEF)));
    plan.push_back(upd_row(0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0, FOV_RESTORE + 1));
    plan.push_back(tick_row(1'b1, pose_of(0, 0, 0, 0, 0, FOV_LO)));
    plan.push_back(upd_row(511, 511, 511, 511, 511, 1'b0, 1'b0, 1'b1, 1'b1, 0));
    plan.push_back(tick_row(1'b0, '0));
    plan.push_back(tick_row(1'b0, '0));
    plan.push_back(upd_row(-512, -512, -512, -512, -512, 1'b0, 1'b0, 1'b0, 1'b0, -1));
    plan.push_back(tick_row(1'b0, '0));
    plan.push_back(tick_row(1'b0, '0));
    plan.push_back(upd_row(256, -256, 256, -256, 256, 1'b1, 1'b0, 1'b1, 1'b0, 0));
    plan.push_back(tick_row(1'b0, '0));
    plan.push_back(upd_row(0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0, 0));
    plan.push_back(tick_row(1'b0, '0));
    plan.push_back(upd_row(-256, 256, -256, 256, -256, 1'b1, 1'b1, 1'b0, 1'b1, 100));
    plan.push_back(tick_row(1'b0, '0));
    plan.push_back(upd_row(-1, 1, -1, 1, -1, 1'b0, 1'b0, 1'b1, 1'b1, FOV_RESTORE + UNIT));
    plan.push_back(tick_row(1'b0, '0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_gap = 14;
    recv_gap = 47;
    foreach (plan[i]) send_item(plan[i].cmd, plan[i].w, plan[i].typed, plan[i].pose);
    in_tvalid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: load_regs(65536, 65535, 65535, 65535, 65535);
        1: load_regs(0, 0, 0, 0, 0);
        2: load_regs(131071, 300, 100, 700, 50);
        3: load_regs($urandom_range(131071), $urandom_range(1023), $urandom_range(1023),
                     $urandom_range(1023), $urandom_range(1023));
        4: load_regs($urandom_range(131071), $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(65535));
        default: load_regs(longint'(ACCEL_RST), 512, 256, 512, 256);
      endcase
      if (ph < 2) begin
        send_gap = 14;
        recv_gap = 47;
      end else if (ph < 4) begin
        send_gap = 47;
        recv_gap = 14;
      end else begin
        send_gap = 0;
        recv_gap = 0;
      end
      sent = 0;
      while (sent < RANDOM_ITEMS / NUM_PHASES) begin
        if ($urandom_range(9) == 0) begin
          send_item($urandom_range(1) ? CMD_TICK : CMD_UPDATE, random_word(), 1'b0, '0);
          sent++;
        end else begin
          send_item(CMD_UPDATE, random_update(), 1'b0, '0);
          sent++;
          burst = $urandom_range(12, 1);
          repeat (burst) begin
            send_item(CMD_TICK, random_word(), 1'b0, '0);
            sent++;
          end
        end
      end
      in_tvalid <= 1'b0;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/scmi_pkg.sv
src/scmi_cfg_regs.sv
src/scmi_axis.sv
src/scmi_pose.sv
src/smoothed_camera_motion_integrator.sv
dv/smoothed_camera_motion_integrator_tb.sv
